// ===== sv/xml_entity_unescape_top_defines.svh =====
// assertion macros for the entity decoder checker
`ifndef XML_ENTITY_UNESCAPE_TOP_DEFINES_SVH
`define XML_ENTITY_UNESCAPE_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define XEU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xeu check failed");

// antecedent implies consequent in the next cycle
`define XEU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xeu check failed");

`endif

// ===== sv/xeu_pkg.sv =====
`default_nettype none
package xeu_pkg;

  localparam int unsigned NumEnt    = 5;
  localparam int unsigned HoldDepth = 5;
  localparam int unsigned EntMax    = 6;

  localparam logic [7:0] AmpChar = 8'h26;

  // entity spellings in lower case, order quot, apos, amp, lt, gt
  localparam logic [7:0] EntText [NumEnt][EntMax] = '{
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}
  };
  localparam logic [2:0] EntLen [NumEnt] = '{3'd6, 3'd6, 3'd5, 3'd4, 3'd4};
  localparam logic [7:0] EntChar [NumEnt] = '{8'h22, 8'h27, 8'h26, 8'h3c, 8'h3e};

  // one queued command: flush cnt held bytes, then optionally one extra byte
  typedef struct packed {
    logic [HoldDepth-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      extra_v;
    logic [7:0]                extra;
    logic                      last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/xeu_front.sv =====
`default_nettype none
module xeu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          push_o,
  output xeu_pkg::cmd_t cmd_o,
  input  logic          push_ready_i
);

  logic [2:0]                       held_cnt_q, held_cnt_d;
  logic [xeu_pkg::NumEnt-1:0]       live_q, live_d;
  logic [7:0]                       held_q [xeu_pkg::HoldDepth];

  logic                             accept;
  logic [7:0]                       c;
  logic [xeu_pkg::NumEnt-1:0]       next_live;
  logic                             done;
  logic [7:0]                       done_char;
  logic                             extend;
  logic                             mismatch;
  logic                             start;
  logic                             idle_hold;

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;

  always_comb begin
    c         = (in_byte_i >= 8'h41 && in_byte_i <= 8'h5a) ? in_byte_i + 8'h20 : in_byte_i;
    next_live = '0;
    done      = 1'b0;
    done_char = '0;
    for (int t = 0; t < xeu_pkg::NumEnt; t++) begin
      if (live_q[t] && held_cnt_q < xeu_pkg::EntLen[t] &&
          c == xeu_pkg::EntText[t][held_cnt_q]) begin
        next_live[t] = 1'b1;
        if (held_cnt_q + 3'd1 == xeu_pkg::EntLen[t]) begin
          done      = 1'b1;
          done_char = done_char | xeu_pkg::EntChar[t];
        end
      end
    end

    idle_hold = (held_cnt_q == 3'd0);
    extend    = !idle_hold && !done && (next_live != '0) &&
                (held_cnt_q < 3'(xeu_pkg::HoldDepth));
    mismatch  = !idle_hold && !done && !extend;
    start     = (idle_hold || mismatch) && (in_byte_i == xeu_pkg::AmpChar) && !in_last_i;

    held_cnt_d = held_cnt_q;
    live_d     = live_q;
    if (accept) begin
      if (start) begin
        held_cnt_d = 3'd1;
        live_d     = '1;
      end else if (extend && !in_last_i) begin
        held_cnt_d = held_cnt_q + 3'd1;
        live_d     = next_live;
      end else begin
        held_cnt_d = 3'd0;
        live_d     = '0;
      end
    end

    // a partial entity cut off by the last byte flushes with that byte included
    for (int i = 0; i < xeu_pkg::HoldDepth; i++) begin
      cmd_o.bytes[i] = (extend && held_cnt_q == 3'(i)) ? in_byte_i : held_q[i];
    end
    if (extend && in_last_i) begin
      cmd_o.cnt = held_cnt_q + 3'd1;
    end else if (mismatch) begin
      cmd_o.cnt = held_cnt_q;
    end else begin
      cmd_o.cnt = 3'd0;
    end
    cmd_o.extra_v = done || ((idle_hold || mismatch) && !start);
    cmd_o.extra   = done ? done_char : in_byte_i;
    cmd_o.last    = in_last_i;

    push_o = accept && (cmd_o.cnt != 3'd0 || cmd_o.extra_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      live_q     <= '0;
    end else begin
      held_cnt_q <= held_cnt_d;
      live_q     <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < xeu_pkg::HoldDepth; i++) begin
        if (start && i == 0) begin
          held_q[i] <= xeu_pkg::AmpChar;
        end else if (extend && !in_last_i && held_cnt_q == 3'(i)) begin
          held_q[i] <= in_byte_i;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/xeu_fifo.sv =====
`default_nettype none
module xeu_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  xeu_pkg::cmd_t data_i,
  output logic          push_ready_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output xeu_pkg::cmd_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  xeu_pkg::cmd_t  mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           do_push;
  logic           do_pop;

  assign push_ready_o = (count_q != CW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/xeu_back.sv =====
`default_nettype none
module xeu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  xeu_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  input  logic          out_ready_i
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [2:0] idx_q, idx_d;

  logic       load;
  logic [2:0] total;
  logic       at_end;
  logic [7:0] elem;

  always_comb begin
    load   = head_valid_i && (!out_valid_q || out_ready_i);
    total  = head_i.cnt + {2'b00, head_i.extra_v};
    at_end = (idx_q == total - 3'd1);
    // held bytes first, then the extra byte
    elem = head_i.extra;
    for (int i = 0; i < xeu_pkg::HoldDepth; i++) begin
      if (idx_q == 3'(i) && idx_q < head_i.cnt) begin
        elem = head_i.bytes[i];
      end
    end
    pop_o = load && at_end;

    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    idx_d       = idx_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_byte_d  = elem;
      out_last_d  = head_i.last && at_end;
      idx_d       = at_end ? 3'd0 : idx_q + 3'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== sv/xml_entity_unescape_top.sv =====
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_byte_i, in_last_i
// out       output     out_valid_o / out_ready_i out_byte_o, out_last_o
//
// the front classifies one byte per cycle, unless the queue is full, against the five
// entities and queues a flush command; the back drains each command one output byte
// per cycle while out_ready_i is high. sustained rate is then one input byte per cycle;
// a flush of n bytes holds the output port, absorbed by the QueueDepth-entry command queue.
// a flush command is registered in the command queue, then its bytes in the output register.
// reset is asynchronous and active low and empties the queue and the match state.
// in_ready_o drops only while the command queue is full.
`default_nettype none
module xml_entity_unescape_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic          push;
  logic          push_ready;
  xeu_pkg::cmd_t cmd;
  logic          head_valid;
  xeu_pkg::cmd_t head;
  logic          pop;

  xeu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .cmd_o        (cmd),
    .push_ready_i (push_ready)
  );

  xeu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_i       (cmd),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  xeu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
`default_nettype wire

// ===== sv/xeu_checker.sv =====
`default_nettype none
`include "xml_entity_unescape_top_defines.svh"
module xeu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  logic out_stall;
  logic in_xfer;
  logic in_payload_seen;

  assign out_stall       = out_valid_o && !out_ready_i;
  assign in_xfer         = in_valid_i && in_ready_o;
  assign in_payload_seen = in_last_i || (in_byte_i != 8'h00) || !in_last_i;

  // a stalled result keeps its valid and payload
  `XEU_ASSERT_NEXT(a_out_hold, out_stall && in_payload_seen,
                   out_valid_o && $stable(out_byte_o) && $stable(out_last_o))

  // back pressure at the input only when results are backing up
  `XEU_ASSERT_NOW(a_full_means_busy, !in_ready_o, out_valid_o || $past(in_xfer))

  // a full queue behind a completed transaction keeps the output fed
  `XEU_ASSERT_NEXT(a_full_refills, out_valid_o && out_ready_i && !in_ready_o, out_valid_o)

endmodule

bind xml_entity_unescape_top xeu_checker u_xeu_checker (.*);
`default_nettype wire
